/* src/bsm_pkg.sv */
package bsm_pkg;

  // bus access commands
  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_t;

  // memory selected by an access
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_PRGRAM = 3'd1,
    KIND_PRGROM = 3'd2,
    KIND_CHR    = 3'd3,
    KIND_VRAM   = 3'd4
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_PRG_UNITS   = 2'd0;
  localparam logic [1:0] REG_CHR_RAM     = 2'd1;
  localparam logic [1:0] REG_ARRANGEMENT = 2'd2;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned MADDR_W    = 22;

  localparam logic [1:0] LOW_SAT = 2'd3;

endpackage

/* src/bank_switch_mapper_with_scanline_irq.sv */
// cartridge bank-switch mapper with scanline irq. each request is one cartridge bus
// access (cpu read/write or ppu read/write) and yields exactly one result: the memory it
// selects, the offset into that memory, and the irq pending flag after the access. cpu
// writes at $8000-$ffff program the eight bank registers, bank modes, prg ram control,
// mirroring and the irq counter. every ppu access feeds an a12 filter: a rising a12 edge
// after three or more a12-low accesses on new cpu cycles clocks the reload-or-decrement
// counter. rate: one request per clock while out_tready does not stall the result
// channel; the result is registered in the output register, with the decode and state
// update combinational between the input port and that register. the output register
// frees itself when taken, so a new request is accepted in the same cycle a waiting
// result leaves. config registers (prg_rom_units at 0x0, chr_ram_present at 0x4, the
// mirroring arrangement bit at 0x8) are written over the apb port; the user must write
// them while idle, not enforced by the block; an arrangement write reloads mirroring.
module bank_switch_mapper_with_scanline_irq (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // address[15:0], write_data[23:16], new_cpu_cycle[24], zero fill
  input  logic [bsm_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd[1:0]
  input  logic [1:0]                         in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // mapped_address[21:0], irq_request[22], zero fill
  output logic [bsm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // access_kind[2:0]
  output logic [2:0]                         out_tuser,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsm_pkg::CFG_AW-1:0]         paddr,
  input  logic [bsm_pkg::CFG_DW-1:0]         pwdata,
  output logic [bsm_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);
  import bsm_pkg::*;

  // configuration
  logic [7:0] prg_units_r;
  logic       chr_ram_r;
  logic       arrangement_r;

  // mapper state
  logic [7:0] bank_r [8];
  logic [2:0] reg_sel_r;
  logic       prg_mode_r;
  logic       chr_mode_r;
  logic       wprot_r;
  logic       ram_en_r;
  logic       mirror_h_r;
  logic [7:0] irq_cnt_r;
  logic [7:0] irq_reload_r;
  logic       irq_on_r;
  logic       irq_flag_r;
  logic       last_a12_r;
  logic [1:0] low_cnt_r;

  // next state
  logic [7:0] bank_nxt [8];
  logic [2:0] reg_sel_nxt;
  logic       prg_mode_nxt;
  logic       chr_mode_nxt;
  logic       wprot_nxt;
  logic       ram_en_nxt;
  logic       mirror_h_nxt;
  logic [7:0] irq_cnt_nxt;
  logic [7:0] irq_reload_nxt;
  logic       irq_on_nxt;
  logic       irq_flag_nxt;
  logic       last_a12_nxt;
  logic [1:0] low_cnt_nxt;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  kind_t                 out_kind_r;

  // request fields
  cmd_t        cmd;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        new_cyc;

  assign cmd     = cmd_t'(in_tuser);
  assign addr    = in_tdata[15:0];
  assign wdata   = in_tdata[23:16];
  assign new_cyc = in_tdata[24];

  logic in_acc;
  logic cfg_wr;
  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;

  // address decode
  logic in_ram_win;
  logic in_rom_win;
  assign in_ram_win = (addr[15:13] == 3'b011);
  assign in_rom_win = addr[15];

  // fixed prg banks: last and second-last 8 KiB banks, modulo 512
  logic [8:0] fixed_last;
  logic [8:0] fixed_2nd;
  assign fixed_last = {prg_units_r, 1'b0} - 9'd1;
  assign fixed_2nd  = {prg_units_r, 1'b0} - 9'd2;

  // prg window select
  logic [1:0] prg_win;
  logic [8:0] prg_bank;
  assign prg_win = addr[14:13];
  always_comb begin
    if (prg_win == 2'd1) begin
      prg_bank = {1'b0, bank_r[7]};
    end else if (prg_win == 2'd3) begin
      prg_bank = fixed_last;
    end else if ((prg_win == 2'd0) == prg_mode_r) begin
      prg_bank = fixed_2nd;
    end else begin
      prg_bank = {1'b0, bank_r[6]};
    end
  end

  // chr 1 KiB slot select; slots 0-3 pair into 2 KiB banks from R0/R1
  logic [2:0]  chr_slot;
  logic [7:0]  chr_bank;
  logic [10:0] chr_off;
  logic [18:0] chr_addr;
  assign chr_slot = addr[12:10] ^ {chr_mode_r, 2'b00};
  always_comb begin
    if (!chr_slot[2]) begin
      chr_bank = bank_r[{2'b00, chr_slot[1]}];
      chr_off  = addr[10:0];
    end else begin
      chr_bank = bank_r[chr_slot - 3'd2];
      chr_off  = {1'b0, addr[9:0]};
    end
  end
  assign chr_addr = {1'b0, chr_bank, 10'd0} + {8'd0, chr_off};

  // nametable mirroring into 2 KiB
  logic [10:0] vram_addr;
  assign vram_addr = mirror_h_r ? {addr[11], addr[9:0]} : addr[10:0];

  // result and state update for one request
  kind_t              kind;
  logic [MADDR_W-1:0] maddr;
  logic [7:0]         bank_wd;
  logic [7:0]         cnt_clk;

  always_comb begin
    bank_nxt       = bank_r;
    reg_sel_nxt    = reg_sel_r;
    prg_mode_nxt   = prg_mode_r;
    chr_mode_nxt   = chr_mode_r;
    wprot_nxt      = wprot_r;
    ram_en_nxt     = ram_en_r;
    mirror_h_nxt   = mirror_h_r;
    irq_cnt_nxt    = irq_cnt_r;
    irq_reload_nxt = irq_reload_r;
    irq_on_nxt     = irq_on_r;
    irq_flag_nxt   = irq_flag_r;
    last_a12_nxt   = last_a12_r;
    low_cnt_nxt    = low_cnt_r;
    kind           = KIND_NONE;
    maddr          = '0;

    // bank register data masking
    bank_wd = wdata;
    if (reg_sel_r >= 3'd6) begin
      bank_wd = wdata & 8'h3F;
    end else if (reg_sel_r <= 3'd1) begin
      bank_wd = wdata & 8'hFE;
    end

    // counter value when the counter is clocked: reload at zero, else decrement
    cnt_clk = (irq_cnt_r == 8'd0) ? irq_reload_r : irq_cnt_r - 8'd1;

    case (cmd)
      CMD_CPU_RD: begin
        if (in_ram_win && ram_en_r) begin
          kind  = KIND_PRGRAM;
          maddr = {9'd0, addr[12:0]};
        end else if (in_rom_win) begin
          kind  = KIND_PRGROM;
          maddr = {prg_bank, addr[12:0]};
        end
      end
      CMD_CPU_WR: begin
        if (in_ram_win && ram_en_r && !wprot_r) begin
          kind  = KIND_PRGRAM;
          maddr = {9'd0, addr[12:0]};
        end else if (in_rom_win) begin
          case (addr[14:13])
            2'd0: begin
              if (addr[0]) begin
                bank_nxt[reg_sel_r] = bank_wd;
              end else begin
                reg_sel_nxt  = wdata[2:0];
                prg_mode_nxt = wdata[6];
                chr_mode_nxt = wdata[7];
              end
            end
            2'd1: begin
              if (addr[0]) begin
                wprot_nxt  = wdata[6];
                ram_en_nxt = wdata[7];
              end else begin
                mirror_h_nxt = wdata[0];
              end
            end
            2'd2: begin
              if (addr[0]) begin
                irq_cnt_nxt = 8'd0;
              end else begin
                irq_reload_nxt = wdata;
              end
            end
            default: begin
              if (addr[0]) begin
                irq_on_nxt = 1'b1;
              end else begin
                irq_on_nxt   = 1'b0;
                irq_flag_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      default: begin
        // a12 edge filter, sees the raw address bit
        if (!addr[12]) begin
          if (new_cyc && low_cnt_r != LOW_SAT) begin
            low_cnt_nxt = low_cnt_r + 2'd1;
          end
        end else if (!last_a12_r) begin
          if (low_cnt_r == LOW_SAT) begin
            irq_cnt_nxt = cnt_clk;
            if (cnt_clk == 8'd0 && irq_on_r) begin
              irq_flag_nxt = 1'b1;
            end
          end
          low_cnt_nxt = 2'd0;
        end
        last_a12_nxt = addr[12];

        if (addr[15:13] != 3'b000) begin
          kind  = KIND_VRAM;
          maddr = {11'd0, vram_addr};
        end else if (cmd == CMD_PPU_RD) begin
          kind  = KIND_CHR;
          maddr = {3'd0, chr_addr};
        end else if (chr_ram_r) begin
          kind  = KIND_CHR;
          maddr = {9'd0, addr[12:0]};
        end
      end
    endcase
  end

  // state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_units_r   <= 8'd2;
      chr_ram_r     <= 1'b0;
      arrangement_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= 8'd0;
      end
      reg_sel_r     <= 3'd0;
      prg_mode_r    <= 1'b0;
      chr_mode_r    <= 1'b0;
      wprot_r       <= 1'b0;
      ram_en_r      <= 1'b0;
      mirror_h_r    <= 1'b1;
      irq_cnt_r     <= 8'd0;
      irq_reload_r  <= 8'd0;
      irq_on_r      <= 1'b0;
      irq_flag_r    <= 1'b0;
      last_a12_r    <= 1'b0;
      low_cnt_r     <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        bank_r       <= bank_nxt;
        reg_sel_r    <= reg_sel_nxt;
        prg_mode_r   <= prg_mode_nxt;
        chr_mode_r   <= chr_mode_nxt;
        wprot_r      <= wprot_nxt;
        ram_en_r     <= ram_en_nxt;
        irq_cnt_r    <= irq_cnt_nxt;
        irq_reload_r <= irq_reload_nxt;
        irq_on_r     <= irq_on_nxt;
        irq_flag_r   <= irq_flag_nxt;
        last_a12_r   <= last_a12_nxt;
        low_cnt_r    <= low_cnt_nxt;
      end

      // the user must send config writes only while idle; the block does not enforce it
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_PRG_UNITS:   prg_units_r   <= pwdata[7:0];
          REG_CHR_RAM:     chr_ram_r     <= pwdata[0];
          REG_ARRANGEMENT: arrangement_r <= pwdata[0];
          default: ;
        endcase
      end

      // writing the arrangement reloads mirroring, else requests update it
      if (cfg_wr && paddr[3:2] == REG_ARRANGEMENT) begin
        mirror_h_r <= ~pwdata[0];
      end else if (in_acc) begin
        mirror_h_r <= mirror_h_nxt;
      end

      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0, irq_flag_nxt, maddr};
      out_kind_r <= kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_PRG_UNITS:   prdata = {24'd0, prg_units_r};
      REG_CHR_RAM:     prdata = {31'd0, chr_ram_r};
      REG_ARRANGEMENT: prdata = {31'd0, arrangement_r};
      default:         prdata = '0;
    endcase
  end

endmodule
